// ----- design/sct_pkg.sv -----
// Shared types, constants and the character class table for the s-expression tokenizer.
// No dependencies; used by every module of the block.
package sct_pkg;

   localparam int MAX_TOKEN_LEN_DEF = 64;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic CMD_CHAR  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [2:0] CLS_WS      = 3'd0;
   localparam logic [2:0] CLS_SYMBOL  = 3'd1;
   localparam logic [2:0] CLS_PAREN   = 3'd2;
   localparam logic [2:0] CLS_COMMENT = 3'd3;
   localparam logic [2:0] CLS_QUOTE   = 3'd4;
   localparam logic [2:0] CLS_CR      = 3'd5;
   localparam logic [2:0] CLS_ESCAPE  = 3'd6;

   typedef struct packed {
      logic       cmd;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_out;
      logic [6:0] token_length;
      logic       overflowed;
      logic       last;
   } rsp_type;

   // one queued job: an optional token end followed by an optional character
   typedef struct packed {
      logic       end_valid;
      logic [6:0] end_len;
      logic       end_ovf;
      logic       char_valid;
      logic [7:0] ch;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [2:0] char_class(input logic [7:0] ch);
      logic [2:0] cls;
      cls = CLS_SYMBOL;
      if (ch[7]) begin
         cls = CLS_WS;
      end else begin
         case (ch[6:0]) inside
            7'd13:             cls = CLS_CR;
            [7'd0:7'd32]:      cls = CLS_WS;
            7'd127:            cls = CLS_WS;
            7'd34, 7'd96:      cls = CLS_QUOTE;
            7'd35, 7'd59:      cls = CLS_COMMENT;
            [7'd39:7'd41]:     cls = CLS_PAREN;
            7'd92:             cls = CLS_ESCAPE;
            default:           cls = CLS_SYMBOL;
         endcase
      end
      return cls;
   endfunction

endpackage

// ----- design/sct_front.sv -----
// Front end: accepts words, classifies characters and keeps the lexer state.
// Emits one job per word that causes results. Depends on sct_pkg.
module sct_front #(
   parameter int MAX_TOKEN_LEN = sct_pkg::MAX_TOKEN_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  sct_pkg::req_type req_data,
   output logic             push,
   output sct_pkg::job_type job
);

   localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

   logic [2:0]       prev_class_ff, prev_class_in;
   logic             quote_ff, quote_in;
   logic             comment_ff, comment_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             exceeded_ff, exceeded_in;

   logic [2:0]       cls;
   logic [7:0]       len8;
   logic             do_end;
   logic [LEN_W-1:0] len_base;
   logic             exc_base;

   assign cls  = sct_pkg::char_class(req_data.ch);
   assign len8 = 8'(len_ff);

   always_comb begin
      prev_class_in = prev_class_ff;
      quote_in      = quote_ff;
      comment_in    = comment_ff;
      len_in        = len_ff;
      exceeded_in   = exceeded_ff;
      do_end        = 1'b0;
      len_base      = len_ff;
      exc_base      = exceeded_ff;
      job           = '0;
      job.end_len   = len8[6:0];
      job.end_ovf   = exceeded_ff;
      job.ch        = req_data.ch;
      if (req_data.cmd == sct_pkg::CMD_FLUSH) begin
         job.end_valid = 1'b1;
         len_in        = '0;
         exceeded_in   = 1'b0;
         prev_class_in = sct_pkg::CLS_WS;
      end else if (comment_ff) begin
         if (cls == sct_pkg::CLS_CR) comment_in = 1'b0;
      end else if (cls == sct_pkg::CLS_COMMENT && !quote_ff) begin
         comment_in = 1'b1;
      end else if (cls == sct_pkg::CLS_QUOTE && prev_class_ff != sct_pkg::CLS_ESCAPE) begin
         quote_in = !quote_ff;
      end else begin
         do_end = (cls != prev_class_ff || cls == sct_pkg::CLS_PAREN) && !quote_ff
                  && prev_class_ff != sct_pkg::CLS_WS;
         if (do_end) begin
            job.end_valid = 1'b1;
            len_base      = '0;
            exc_base      = 1'b0;
         end
         len_in      = len_base;
         exceeded_in = exc_base;
         if (cls != sct_pkg::CLS_WS || quote_ff) begin
            if (len_base < LEN_W'(MAX_TOKEN_LEN)) begin
               job.char_valid = 1'b1;
               len_in         = len_base + 1'b1;
            end else begin
               exceeded_in = 1'b1;
            end
         end
         prev_class_in = cls;
      end
   end

   assign push = accept && (job.end_valid || job.char_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_class_ff <= sct_pkg::CLS_WS;
         quote_ff      <= 1'b0;
         comment_ff    <= 1'b0;
         len_ff        <= '0;
         exceeded_ff   <= 1'b0;
      end else if (accept) begin
         prev_class_ff <= prev_class_in;
         quote_ff      <= quote_in;
         comment_ff    <= comment_in;
         len_ff        <= len_in;
         exceeded_ff   <= exceeded_in;
      end
   end

endmodule

// ----- design/sct_queue.sv -----
// Short job queue between front and back end, register based.
// Depends on sct_pkg.
module sct_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sct_pkg::job_type          push_job,
   input  logic                      pop,
   output sct_pkg::job_type          head,
   output sct_pkg::queue_status_type status
);

   localparam int DEPTH = sct_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sct_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// ----- design/sct_back.sv -----
// Back end: turns queued jobs into result words through an output register.
// Depends on sct_pkg.
module sct_back (
   input  logic                      clock,
   input  logic                      reset,
   input  sct_pkg::job_type          head,
   input  sct_pkg::queue_status_type status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sct_pkg::rsp_type          rsp_data
);

   logic             valid_ff, valid_in;
   logic             phase_ff, phase_in;
   sct_pkg::rsp_type data_ff, data_in;
   logic             load;

   assign load = !valid_ff || !rsp_stall;

   always_comb begin
      pop      = 1'b0;
      valid_in = valid_ff;
      phase_in = phase_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = !status.empty;
         if (!status.empty) begin
            data_in = '0;
            if (!phase_ff && head.end_valid) begin
               data_in.kind         = sct_pkg::KIND_END;
               data_in.token_length = head.end_len;
               data_in.overflowed   = head.end_ovf;
               data_in.last         = !head.char_valid;
               if (head.char_valid) phase_in = 1'b1;
               else                 pop      = 1'b1;
            end else begin
               data_in.kind     = sct_pkg::KIND_CHAR;
               data_in.char_out = head.ch;
               data_in.last     = 1'b1;
               pop              = 1'b1;
               phase_in         = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- design/sexpr_char_tokenizer.sv -----
// The first result word of an accepted input word passes through the job queue and the output
// register to rsp. Throughput: one input word per cycle while each word yields at most one
// result and rsp_stall is low; a word with a token end and a character yields two results,
// so a run of those fills the 4-entry job queue and stalls input. req_stall rises only while
// that queue is full. Reset (synchronous) clears lexer state, queue pointers, output valid.
// Depends on sct_pkg, sct_front, sct_queue, sct_back.
module sexpr_char_tokenizer #(
   parameter int MAX_TOKEN_LEN = sct_pkg::MAX_TOKEN_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sct_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sct_pkg::rsp_type rsp_data
);

   sct_pkg::job_type          job, head;
   sct_pkg::queue_status_type status;
   logic                      push, pop, accept;

   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   sct_front #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push),
      .job      (job)
   );

   sct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (job),
      .pop      (pop),
      .head     (head),
      .status   (status)
   );

   sct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/sct_checker.sv -----
// Port-level checks on the tokenizer's result channel, bound to the top level.
// Depends on sct_pkg and sexpr_char_tokenizer.
module sct_checker #(
   parameter int MAX_TOKEN_LEN = sct_pkg::MAX_TOKEN_LEN_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sct_pkg::rsp_type rsp_data
);

   localparam logic [7:0] MAX8 = 8'(MAX_TOKEN_LEN);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_char_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == sct_pkg::KIND_CHAR |->
         rsp_data.last && rsp_data.token_length == '0 && !rsp_data.overflowed)
      else $error("malformed character word");

   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == sct_pkg::KIND_END |-> rsp_data.char_out == '0)
      else $error("token end word carries a character");

   a_ovf_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == sct_pkg::KIND_END && rsp_data.overflowed |->
         rsp_data.token_length == MAX8[6:0])
      else $error("overflowed token not at maximum length");

endmodule

bind sexpr_char_tokenizer sct_checker #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_sct_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
